// ----- design/framed_record_ring_buffer_assert.svh -----
// Assertion macros shared by the ring buffer RTL.
`ifndef FRAMED_RECORD_RING_BUFFER_ASSERT_SVH
`define FRAMED_RECORD_RING_BUFFER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define FRB_CHECK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define FRB_CHECK_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ----- design/frb_pkg.sv -----
// Types and constants of the framed record ring buffer.
package frb_pkg;

   localparam int unsigned RING_BYTES_DEF       = 4096;
   localparam int unsigned MAX_RECORD_BYTES_DEF = 1024;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned LEN_W    = 11;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;

   localparam int unsigned HEADER_BYTES = 5;
   localparam int unsigned GUARD_BYTES  = 16;
   // finalize writes: 4 length bytes, 5 terminator bytes, then the valid byte
   localparam int unsigned FIN_LAST     = 2 * HEADER_BYTES - 1;
   localparam int unsigned STEP_W       = 4;

   localparam logic [BYTE_W-1:0] VALID_MARK = 8'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_OPEN    = 2'd0,
      OP_PAYLOAD = 2'd1,
      OP_READ    = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_SEQ   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RCL_CHECK,
      ST_RCL_HDR,
      ST_RCL_STEP,
      ST_OPEN_END,
      ST_PAY_WR,
      ST_PAY_FIN,
      ST_RD_HDR,
      ST_RD_ISSUE,
      ST_RD_CAP
   } state_type;

endpackage

// ----- design/frb_ring_ram.sv -----
// Byte ring memory: one write port, one read port with registered data.
module frb_ring_ram #(
   parameter int unsigned RING_BYTES = frb_pkg::RING_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(RING_BYTES)-1:0] wr_addr,
   input  logic [frb_pkg::BYTE_W-1:0]    wr_data,
   input  logic [$clog2(RING_BYTES)-1:0] rd_addr,
   output logic [frb_pkg::BYTE_W-1:0]    rd_data
);
   import frb_pkg::*;

   logic [BYTE_W-1:0] mem_ff [RING_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/framed_record_ring_buffer.sv -----
// Top level of the framed record ring buffer: sequencer, pointers and response.
//
//   Channel   Ports                                        Handshake
//   --------  -------------------------------------------  -------------------------
//   request   req_opcode, req_record_length, req_data_byte  taken when start & !busy
//   response  rsp_status, rsp_read_byte, rsp_read_last     one cycle, rsp_strobe high
//
// Sequence errors are answered straight from idle. A payload byte is written; the last
// byte of a record is followed by ten finalize writes. A read fetches the header, then
// reads one payload byte through the single read port, or answers empty when no valid
// record is there. An open walks consumed records and stops on a live or terminator
// header.
// After reset the ring is zeroed one byte a cycle, with busy high throughout.
// The response side cannot stall; a response may overlap acceptance of the next item.
// Records are framed as valid byte, 32-bit big-endian length, payload; a finished
// record is followed by a zero terminator header. One ring address adder (base plus offset,
// wrapped by one compare and subtract) serves every access but clear and valid-byte writes.
module framed_record_ring_buffer #(
   parameter int unsigned RING_BYTES       = frb_pkg::RING_BYTES_DEF,
   parameter int unsigned MAX_RECORD_BYTES = frb_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [frb_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [frb_pkg::LEN_W-1:0]      req_record_length,
   input  logic [frb_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                           rsp_strobe,
   output logic [frb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [frb_pkg::BYTE_W-1:0]     rsp_read_byte,
   output logic                           rsp_read_last
);
   import frb_pkg::*;

   `include "framed_record_ring_buffer_assert.svh"

   localparam int unsigned PTR_W = $clog2(RING_BYTES);
   localparam int unsigned OFF_W = PTR_W + 1;
   localparam int unsigned SUM_W = PTR_W + 2;
   localparam int unsigned CHK_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
   // the request length field cannot exceed its own range
   localparam int unsigned LEN_CAP = (MAX_RECORD_BYTES > (2 ** LEN_W - 1)) ?
                                     (2 ** LEN_W - 1) : MAX_RECORD_BYTES;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_CAP);

   // sequencer and pointers
   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rcl_ff, rcl_in;
   logic [PTR_W-1:0]  rdp_ff, rdp_in;
   logic [PTR_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic              rec_open_ff, rec_open_in;
   logic [LEN_W-1:0]  open_len_ff, open_len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]  roff_ff, roff_in;
   logic [OFF_W-1:0]  hops_ff, hops_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BYTE_W-1:0] hdr_valid_ff, hdr_valid_in;
   logic [31:0]       hdr_len_ff, hdr_len_in;

   // latched request payload
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0] data_ff, data_in;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // shared ring adder
   logic [PTR_W-1:0]  add_base;
   logic [OFF_W-1:0]  add_off;
   logic [SUM_W-1:0]  add_sum;
   logic [PTR_W-1:0]  add_res;

   // memory ports
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [PTR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic              accept;
   logic [PTR_W-1:0]  used;
   logic              full;
   logic [LEN_W-1:0]  fill_next;
   logic [LEN_W-1:0]  roff_next;
   logic              rd_last;
   logic [31:0]       len_word;

   frb_ring_ram #(
      .RING_BYTES (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign add_sum = SUM_W'(add_base) + SUM_W'(add_off);
   assign add_res = (add_sum >= SUM_W'(RING_BYTES)) ?
                    PTR_W'(add_sum - SUM_W'(RING_BYTES)) : PTR_W'(add_sum);

   // bytes between reclaim and write pointer
   assign used = (wp_ff >= rcl_ff) ? PTR_W'(wp_ff - rcl_ff) :
                 PTR_W'(OFF_W'(wp_ff) + OFF_W'(RING_BYTES) - OFF_W'(rcl_ff));
   assign full = (CHK_W'(used) + CHK_W'(length_ff) + CHK_W'(GUARD_BYTES)) >
                 CHK_W'(RING_BYTES);

   assign fill_next = fill_ff + LEN_W'(1);
   assign roff_next = roff_ff + LEN_W'(1);
   assign rd_last   = (32'(roff_next) >= hdr_len_ff) || (roff_next == '0);
   assign len_word  = 32'(open_len_ff);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rcl_in        = rcl_ff;
      rdp_in        = rdp_ff;
      clr_ptr_in    = clr_ptr_ff;
      rec_open_in   = rec_open_ff;
      open_len_in   = open_len_ff;
      fill_in       = fill_ff;
      roff_in       = roff_ff;
      hops_in       = hops_ff;
      step_in       = step_ff;
      hdr_valid_in  = hdr_valid_ff;
      hdr_len_in    = hdr_len_ff;
      length_in     = length_ff;
      data_in       = data_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_byte_in   = '0;
      rsp_last_in   = 1'b0;
      add_base      = wp_ff;
      add_off       = '0;
      ram_we        = 1'b0;
      ram_waddr     = wp_ff;
      ram_wdata     = '0;
      ram_raddr     = wp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + PTR_W'(1);
            if (clr_ptr_ff == PTR_W'(RING_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               length_in = req_record_length;
               data_in   = req_data_byte;
               step_in   = '0;
               unique case (req_opcode)
                  OP_OPEN: begin
                     if (rec_open_ff || (req_record_length == '0) ||
                         (req_record_length > LEN_MAX)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_SEQ;
                     end else begin
                        hops_in  = '0;
                        state_in = ST_RCL_CHECK;
                     end
                  end
                  OP_PAYLOAD: begin
                     if (!rec_open_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_SEQ;
                     end else begin
                        state_in = ST_PAY_WR;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_RD_HDR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_SEQ;
                  end
               endcase
            end
         end

         // reclaim walk: stop at write pointer or after RING_BYTES hops
         ST_RCL_CHECK: begin
            step_in = '0;
            if ((rcl_ff == wp_ff) || (hops_ff == OFF_W'(RING_BYTES))) begin
               state_in = ST_OPEN_END;
            end else begin
               state_in = ST_RCL_HDR;
            end
         end

         // header fetch: issue byte k, capture byte k-1
         ST_RCL_HDR, ST_RD_HDR: begin
            add_base  = (state_ff == ST_RCL_HDR) ? rcl_ff : rdp_ff;
            add_off   = OFF_W'(step_ff);
            ram_raddr = add_res;
            if (step_ff == STEP_W'(1)) begin
               hdr_valid_in = ram_rdata;
            end else if (step_ff != '0) begin
               hdr_len_in = {hdr_len_ff[23:0], ram_rdata};
            end
            if (step_ff == STEP_W'(HEADER_BYTES)) begin
               state_in = (state_ff == ST_RCL_HDR) ? ST_RCL_STEP : ST_RD_ISSUE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end

         ST_RCL_STEP: begin
            if ((hdr_valid_ff != '0) || (hdr_len_ff == '0)) begin
               state_in = ST_OPEN_END;
            end else begin
               add_base = rcl_ff;
               add_off  = OFF_W'(HEADER_BYTES) + hdr_len_ff[OFF_W-1:0];
               rcl_in   = add_res;
               hops_in  = hops_ff + OFF_W'(1);
               state_in = ST_RCL_CHECK;
            end
         end

         ST_OPEN_END: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (full) begin
               rsp_status_in = STAT_FULL;
            end else begin
               rec_open_in = 1'b1;
               open_len_in = length_ff;
               fill_in     = '0;
            end
         end

         ST_PAY_WR: begin
            add_base  = wp_ff;
            add_off   = OFF_W'(HEADER_BYTES) + OFF_W'(fill_ff);
            ram_we    = 1'b1;
            ram_waddr = add_res;
            ram_wdata = data_ff;
            fill_in   = fill_next;
            if (fill_next >= open_len_ff) begin
               step_in  = '0;
               state_in = ST_PAY_FIN;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // length, terminator header, then the valid byte last
         ST_PAY_FIN: begin
            add_base = wp_ff;
            ram_we   = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff < STEP_W'(4)) begin
               add_off   = OFF_W'(step_ff) + OFF_W'(1);
               ram_waddr = add_res;
               unique case (step_ff[1:0])
                  2'd0:    ram_wdata = len_word[31:24];
                  2'd1:    ram_wdata = len_word[23:16];
                  2'd2:    ram_wdata = len_word[15:8];
                  default: ram_wdata = len_word[7:0];
               endcase
            end else if (step_ff < STEP_W'(FIN_LAST)) begin
               add_off   = OFF_W'(HEADER_BYTES) + OFF_W'(open_len_ff) +
                           OFF_W'(step_ff) - OFF_W'(4);
               ram_waddr = add_res;
            end else begin
               add_off      = OFF_W'(HEADER_BYTES) + OFF_W'(open_len_ff);
               ram_waddr    = wp_ff;
               ram_wdata    = VALID_MARK;
               wp_in        = add_res;
               rec_open_in  = 1'b0;
               fill_in      = '0;
               open_len_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_RD_ISSUE: begin
            if (hdr_valid_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_EMPTY;
               state_in      = ST_IDLE;
            end else begin
               add_base  = rdp_ff;
               add_off   = OFF_W'(HEADER_BYTES) + OFF_W'(roff_ff);
               ram_raddr = add_res;
               state_in  = ST_RD_CAP;
            end
         end

         ST_RD_CAP: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rdata;
            rsp_last_in  = rd_last;
            state_in     = ST_IDLE;
            if (rd_last) begin
               // retire: clear valid byte, step past the record
               ram_we    = 1'b1;
               ram_waddr = rdp_ff;
               add_base  = rdp_ff;
               add_off   = OFF_W'(HEADER_BYTES) + hdr_len_ff[OFF_W-1:0];
               rdp_in    = add_res;
               roff_in   = '0;
            end else begin
               roff_in = roff_next;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         rcl_ff       <= '0;
         rdp_ff       <= '0;
         clr_ptr_ff   <= '0;
         rec_open_ff  <= 1'b0;
         open_len_ff  <= '0;
         fill_ff      <= '0;
         roff_ff      <= '0;
         hops_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rcl_ff       <= rcl_in;
         rdp_ff       <= rdp_in;
         clr_ptr_ff   <= clr_ptr_in;
         rec_open_ff  <= rec_open_in;
         open_len_ff  <= open_len_in;
         fill_ff      <= fill_in;
         roff_ff      <= roff_in;
         hops_ff      <= hops_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_valid_ff  <= hdr_valid_in;
      hdr_len_ff    <= hdr_len_in;
      length_ff     <= length_in;
      data_ff       <= data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_read_last = rsp_last_ff;

   // every accepted item is either in work or answered in the next cycle
   `FRB_CHECK_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_strobe,
                   "accepted item lost")
   // a response only follows work or an accept
   `FRB_CHECK(a_rsp_has_cause, clock, reset, rsp_strobe |-> $past(busy || start),
              "spurious response")
   // the ring is never written while idle
   `FRB_CHECK(a_idle_no_write, clock, reset, (state_ff == ST_IDLE) |-> !ram_we,
              "write while idle")
   // closing a record coincides with its ok response
   `FRB_CHECK(a_close_answered, clock, reset,
              $fell(rec_open_ff) |-> (rsp_strobe && (rsp_status_ff == STAT_OK)),
              "record closed without response")

endmodule
